>>> rtl/fpx_pkg.sv
// Shared types and constants for the frame parser with XOR checksum.
`timescale 1ns / 1ps
`default_nettype none
package fpx_pkg;

  // Parser phase within one frame
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_MARKER,
    PH_DRAIN
  } phase_t;

  // Header byte positions
  localparam logic [2:0] HDR_SRC    = 3'd0;
  localparam logic [2:0] HDR_TGT    = 3'd1;
  localparam logic [2:0] HDR_CMD_HI = 3'd2;
  localparam logic [2:0] HDR_CMD_LO = 3'd3;
  localparam logic [2:0] HDR_LEN    = 3'd4;

  // Configuration register map
  localparam int          CFG_AW          = 2;
  localparam logic [1:0]  ADDR_END_MARKER = 2'd0;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // One queued result record
  typedef struct packed {
    logic        is_final;
    logic [7:0]  data;
    logic [4:0]  idx;
    logic [7:0]  src;
    logic [7:0]  tgt;
    logic [15:0] cmd;
    logic [7:0]  len;
    logic [7:0]  xsum;
    logic        invalid;
  } rec_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

>>> rtl/fpx_if.sv
// Valid/ready channel interfaces for input bytes and result items.
`timescale 1ns / 1ps
`default_nettype none
interface fpx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_last;
  modport source (output valid, data_byte, buffer_last, input ready);
  modport sink (input valid, data_byte, buffer_last, output ready);
endinterface

interface fpx_out_if;
  logic        valid;
  logic        ready;
  logic        is_final;
  logic [7:0]  payload_byte;
  logic [4:0]  payload_index;
  logic [7:0]  src_id;
  logic [7:0]  dst_id;
  logic [15:0] command;
  logic [7:0]  pay_len;
  logic [7:0]  checksum;
  logic        status;
  modport source (output valid, is_final, payload_byte, payload_index, src_id, dst_id,
                  command, pay_len, checksum, status, input ready);
  modport sink (input valid, is_final, payload_byte, payload_index, src_id, dst_id,
                command, pay_len, checksum, status, output ready);
endinterface
`default_nettype wire

>>> rtl/fpx_front.sv
// Front end: accept bytes, track frame phase, emit result records.
`timescale 1ns / 1ps
`default_nettype none
module fpx_front #(
  parameter int MAX_PAYLOAD = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  fpx_in_if.sink                in_ch,
  input  wire logic [7:0]       end_marker,
  input  wire fpx_pkg::q_stat_t q_stat,
  output logic                  push,
  output fpx_pkg::rec_t         rec
);

  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  fpx_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  hcnt_r, hcnt_nxt;
  logic [7:0]  src_r, src_nxt;
  logic [7:0]  tgt_r, tgt_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  pcnt_r, pcnt_nxt;
  logic [7:0]  xsum_r, xsum_nxt;

  logic accept;
  logic emit_final;
  logic bad;
  logic decided;
  logic restart;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && !q_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fpx_pkg::PH_HEADER;
      hcnt_r  <= '0;
      src_r   <= '0;
      tgt_r   <= '0;
      cmd_r   <= '0;
      len_r   <= '0;
      pcnt_r  <= '0;
      xsum_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      src_r   <= src_nxt;
      tgt_r   <= tgt_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      pcnt_r  <= pcnt_nxt;
      xsum_r  <= xsum_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    hcnt_nxt   = hcnt_r;
    src_nxt    = src_r;
    tgt_nxt    = tgt_r;
    cmd_nxt    = cmd_r;
    len_nxt    = len_r;
    pcnt_nxt   = pcnt_r;
    xsum_nxt   = xsum_r;
    emit_final = 1'b0;
    bad        = 1'b0;
    decided    = 1'b0;
    restart    = 1'b0;
    push       = 1'b0;
    rec        = '0;

    if (accept) begin
      case (phase_r)
        fpx_pkg::PH_HEADER: begin
          xsum_nxt = xsum_r ^ in_ch.data_byte;
          case (hcnt_r)
            fpx_pkg::HDR_SRC:    src_nxt = in_ch.data_byte;
            fpx_pkg::HDR_TGT:    tgt_nxt = in_ch.data_byte;
            fpx_pkg::HDR_CMD_HI: cmd_nxt = {in_ch.data_byte, 8'h00};
            fpx_pkg::HDR_CMD_LO: cmd_nxt = {cmd_r[15:8], in_ch.data_byte};
            default:             len_nxt = in_ch.data_byte;
          endcase
          hcnt_nxt = hcnt_r + 3'd1;
          if (hcnt_r == fpx_pkg::HDR_LEN) begin
            if (in_ch.data_byte > MAX_LEN || in_ch.buffer_last) begin
              emit_final = 1'b1;
              bad        = 1'b1;
              decided    = 1'b1;
            end else begin
              pcnt_nxt  = '0;
              phase_nxt = (in_ch.data_byte != 8'd0) ? fpx_pkg::PH_PAYLOAD
                                                    : fpx_pkg::PH_MARKER;
            end
          end else if (in_ch.buffer_last) begin
            emit_final = 1'b1;
            bad        = 1'b1;
            restart    = 1'b1;
          end
        end
        fpx_pkg::PH_PAYLOAD: begin
          if (in_ch.buffer_last) begin
            emit_final = 1'b1;
            bad        = 1'b1;
            restart    = 1'b1;
          end else begin
            xsum_nxt     = xsum_r ^ in_ch.data_byte;
            push         = 1'b1;
            rec.is_final = 1'b0;
            rec.data     = in_ch.data_byte;
            rec.idx      = pcnt_r[4:0];
            pcnt_nxt     = pcnt_r + 8'd1;
            if (pcnt_nxt >= len_r) begin
              phase_nxt = fpx_pkg::PH_MARKER;
            end
          end
        end
        fpx_pkg::PH_MARKER: begin
          emit_final = 1'b1;
          bad        = (in_ch.data_byte != end_marker);
          decided    = 1'b1;
        end
        default: begin
          // drain trailing bytes until the buffer ends
          restart = in_ch.buffer_last;
        end
      endcase
    end

    if (emit_final) begin
      push         = 1'b1;
      rec.is_final = 1'b1;
      rec.src      = src_nxt;
      rec.tgt      = tgt_nxt;
      rec.cmd      = cmd_nxt;
      rec.len      = len_nxt;
      rec.xsum     = xsum_nxt;
      rec.invalid  = bad;
    end

    if (decided) begin
      if (in_ch.buffer_last) begin
        restart = 1'b1;
      end else begin
        phase_nxt = fpx_pkg::PH_DRAIN;
      end
    end

    if (restart) begin
      phase_nxt = fpx_pkg::PH_HEADER;
      hcnt_nxt  = '0;
      src_nxt   = '0;
      tgt_nxt   = '0;
      cmd_nxt   = '0;
      len_nxt   = '0;
      pcnt_nxt  = '0;
      xsum_nxt  = '0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/fpx_queue.sv
// Short record queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module fpx_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire fpx_pkg::rec_t wdata,
  input  wire logic          pop,
  output fpx_pkg::rec_t      rdata,
  output fpx_pkg::q_stat_t   stat
);

  fpx_pkg::rec_t mem [fpx_pkg::QDEPTH];

  logic [fpx_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [fpx_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [fpx_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == fpx_pkg::QCNT_W'(fpx_pkg::QDEPTH));
  assign rdata      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + fpx_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + fpx_pkg::QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + fpx_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - fpx_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/fpx_back.sv
// Back end: format queued records into result items and hold them in an output register.
`timescale 1ns / 1ps
`default_nettype none
module fpx_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire fpx_pkg::q_stat_t q_stat,
  input  wire fpx_pkg::rec_t    rec,
  output logic                  pop,
  fpx_out_if.source             out_ch
);

  logic        valid_r, valid_nxt;
  logic        fin_r;
  logic [7:0]  byte_r;
  logic [4:0]  idx_r;
  logic [7:0]  src_r;
  logic [7:0]  tgt_r;
  logic [15:0] cmd_r;
  logic [7:0]  len_r;
  logic [7:0]  sum_r;
  logic        stat_r;

  assign pop = !q_stat.empty && (!valid_r || out_ch.ready);

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Zero the fields that do not belong to the record's kind
  always_ff @(posedge clk) begin
    if (pop) begin
      fin_r <= rec.is_final;
      if (rec.is_final) begin
        byte_r <= '0;
        idx_r  <= '0;
        src_r  <= rec.src;
        tgt_r  <= rec.tgt;
        cmd_r  <= rec.cmd;
        len_r  <= rec.len;
        sum_r  <= rec.invalid ? 8'h00 : rec.xsum;
        stat_r <= rec.invalid;
      end else begin
        byte_r <= rec.data;
        idx_r  <= rec.idx;
        src_r  <= '0;
        tgt_r  <= '0;
        cmd_r  <= '0;
        len_r  <= '0;
        sum_r  <= '0;
        stat_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.is_final      = fin_r;
  assign out_ch.payload_byte  = byte_r;
  assign out_ch.payload_index = idx_r;
  assign out_ch.src_id        = src_r;
  assign out_ch.dst_id        = tgt_r;
  assign out_ch.command       = cmd_r;
  assign out_ch.pay_len       = len_r;
  assign out_ch.checksum      = sum_r;
  assign out_ch.status        = stat_r;

endmodule
`default_nettype wire

>>> rtl/frame_parser_xor_checksum.sv
// Top level of the length-prefixed frame parser with XOR checksum.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel   | direction | handshake           | carries
//  ----------+-----------+---------------------+--------------------------------------
//  in_ch     | in        | valid/ready         | data_byte, buffer_last
//  out_ch    | out       | valid/ready         | payload byte item or frame final item
//  APB       | in        | psel/penable/pready | end_marker register at byte address 0
//
//  One byte is taken per cycle while the queue is not full; the front end
//  updates the frame state in the cycle it takes the byte. A result reaches
//  out_ch through the queue write and then the output register.
//  rst_n is synchronous, active low; it returns the parser to the header phase
//  and clears end_marker. in_ch.ready drops only while the four-entry queue is
//  full, so a stalled out_ch backs up into the input after five result items
//  (one held in the output register, four in the queue).
//
module frame_parser_xor_checksum #(
  parameter int MAX_PAYLOAD = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  fpx_in_if.sink                           in_ch,
  fpx_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fpx_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic [7:0]       end_marker_r;
  logic             cfg_wr;
  logic             q_push;
  logic             q_pop;
  fpx_pkg::rec_t    q_wdata;
  fpx_pkg::rec_t    q_rdata;
  fpx_pkg::q_stat_t q_stat;

  // Config port: zero wait states, write lands on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == fpx_pkg::ADDR_END_MARKER);
  assign prdata = (paddr == fpx_pkg::ADDR_END_MARKER) ? {24'h000000, end_marker_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_marker_r <= 8'h00;
    end else if (cfg_wr) begin
      end_marker_r <= pwdata[7:0];
    end
  end

  // Front end: parse and classify each byte
  fpx_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .end_marker (end_marker_r),
    .q_stat     (q_stat),
    .push       (q_push),
    .rec        (q_wdata)
  );

  // Queue decouples parsing from output stalls
  fpx_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back end: format and hold the result item
  fpx_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .rec    (q_rdata),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

  // Front never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("record pushed into full queue");

  // Back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("record popped from empty queue");

  // An invalid frame reports a zero checksum
  a_bad_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.is_final && out_ch.status) |-> (out_ch.checksum == 8'h00))
    else $error("invalid final item with nonzero checksum");

  // A payload item carries no header, checksum or status
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.is_final) |->
      (out_ch.status == 1'b0 && out_ch.checksum == 8'h00 && out_ch.command == 16'h0000))
    else $error("payload item with header fields set");

endmodule
`default_nettype wire
